>>> sv/bqhp_pkg.sv
// Package for the biquad high-pass filter unit: widths, register codes,
// request/result structs and coefficient set type. No dependencies.
`timescale 1ns / 1ps

package bqhp_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int COEF_FRAC    = 29;
    localparam int PROD_W       = COEF_W + SAMPLE_W;   // one coefficient times one sample
    localparam int ACC_W        = PROD_W + 3;          // five products summed
    localparam int CFG_IDX_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd4;

    // 1.0 in Q2.29
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC;

    typedef struct packed {
        logic                       chan;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       restart;
    } item_t;

    typedef struct packed {
        logic                       chan_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } result_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

    // one channel's history: last two inputs, last two outputs
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in1;
        logic signed [SAMPLE_W-1:0] in2;
        logic signed [SAMPLE_W-1:0] out1;
        logic signed [SAMPLE_W-1:0] out2;
    } hist_t;

    localparam coef_set_t COEF_RESET = '{
        b0: COEF_ONE,
        b1: '0,
        b2: '0,
        a1: '0,
        a2: '0
    };

endpackage

>>> sv/biquad_highpass_filter_unit.sv
// Biquad IIR filter, direct form 1, per-channel history.
// Throughput one request per cycle while the result output is not stalled.
// The filter runs between the request register and the result register; the channel
// history is written as the result is captured, so same-channel requests may follow back to back.
// Reset clears all history and loads pass-through coefficients (b0 = 1.0, others 0).
// Depends on bqhp_pkg, bqhp_hist, bqhp_mac.
`timescale 1ns / 1ps

module biquad_highpass_filter_unit
    import bqhp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_set_t coef_reg;
    logic      s1_valid_reg;
    item_t     s1_item_reg;
    logic      result_valid_reg;
    result_t   result_reg;

    logic                       advance;
    hist_t                      hist;
    logic signed [SAMPLE_W-1:0] y;

    assign cfg_ready    = 1'b1;
    assign advance      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COEF_B0: coef_reg.b0 <= cfg_data;
                REG_COEF_B1: coef_reg.b1 <= cfg_data;
                REG_COEF_B2: coef_reg.b2 <= cfg_data;
                REG_COEF_A1: coef_reg.a1 <= cfg_data;
                REG_COEF_A2: coef_reg.a2 <= cfg_data;
                default:     ;
            endcase
        end
    end

    bqhp_hist #(
        .CHANNELS (CHANNELS)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .chan    (s1_item_reg.chan),
        .restart (s1_item_reg.restart),
        .upd     (advance),
        .x       (s1_item_reg.sample_in),
        .y       (y),
        .hist    (hist)
    );

    bqhp_mac u_mac (
        .coef (coef_reg),
        .hist (hist),
        .x    (s1_item_reg.sample_in),
        .y    (y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= '{chan_out: s1_item_reg.chan, sample_out: y};
        end
    end

endmodule

>>> sv/bqhp_hist.sv
// Per-channel filter history (x1, x2, y1, y2) in flip-flops.
// Depends on bqhp_pkg.
`timescale 1ns / 1ps

module bqhp_hist
    import bqhp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       chan,
    input  logic                       restart,
    input  logic                       upd,
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic signed [SAMPLE_W-1:0] y,
    output hist_t                      hist
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    hist_t           hist_reg [CHANNELS];
    logic [CH_W-1:0] ch_idx;

    // chan folds onto the channel count
    assign ch_idx = (CHANNELS == 1) ? '0 : CH_W'(chan);

    // restart makes the channel look freshly cleared for this sample
    assign hist = restart ? '0 : hist_reg[ch_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            hist_reg[ch_idx] <= '{
                in1:  x,
                in2:  hist.in1,
                out1: y,
                out2: hist.out1
            };
        end
    end

endmodule

>>> sv/bqhp_mac.sv
// Biquad arithmetic: five products, sum, round half up, saturate.
// Depends on bqhp_pkg.
`timescale 1ns / 1ps

module bqhp_mac
    import bqhp_pkg::*;
(
    input  coef_set_t                  coef,
    input  hist_t                      hist,
    input  logic signed [SAMPLE_W-1:0] x,
    output logic signed [SAMPLE_W-1:0] y
);

    localparam int YW_W = ACC_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [YW_W-1:0] Y_MAX = YW_W'(SAMPLE_MAX);
    localparam logic signed [YW_W-1:0] Y_MIN = YW_W'(SAMPLE_MIN);

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [YW_W-1:0]   y_wide;

    assign p_b0 = coef.b0 * x;
    assign p_b1 = coef.b1 * hist.in1;
    assign p_b2 = coef.b2 * hist.in2;
    assign p_a1 = coef.a1 * hist.out1;
    assign p_a2 = coef.a2 * hist.out2;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;

    // dropping the fraction bits is a floor shift
    assign y_wide = acc[ACC_W-1:COEF_FRAC];

    always_comb
    begin
        if (y_wide > Y_MAX)
        begin
            y = SAMPLE_MAX;
        end
        else if (y_wide < Y_MIN)
        begin
            y = SAMPLE_MIN;
        end
        else
        begin
            y = y_wide[SAMPLE_W-1:0];
        end
    end

endmodule

>>> sv/bqhp_checker.sv
// Port-level checks for biquad_highpass_filter_unit, bound to the top level.
// Depends on bqhp_pkg.
`timescale 1ns / 1ps

module bqhp_port_checks
    import bqhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  item_t                item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a result that appears out of an empty output matches the request accepted into the request register ahead of it
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(item_valid && item_ready, 2) && result.chan_out == $past(item.chan, 2))
        else $error("result without matching request");

    // only a full, stalled pipeline refuses requests
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("request refused with room in pipeline");

    // a restarted channel fed silence gives silence
    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) &&
            $past(item_valid && item_ready && item.restart && item.sample_in == '0, 2)
            |-> result.sample_out == '0)
        else $error("restart with zero input gave nonzero output");

endmodule

bind biquad_highpass_filter_unit bqhp_port_checks u_bqhp_port_checks (.*);
